>>> hw/rtl/cbt_pkg.sv
// cbt_pkg: shared constants, codes, result struct and map helpers for the
// coverage bitmap new-edge tracker. No dependencies.
package cbt_pkg;

  localparam int unsigned EDGE_CAPACITY = 65536;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned MAP_WORDS     = (EDGE_CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned HIT_AW        = $clog2(EDGE_CAPACITY);
  localparam int unsigned MAP_AW        = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W         = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W        = 10;
  localparam int unsigned EDGE_W        = 16;
  localparam int unsigned COUNT_W       = 17;
  localparam int unsigned COUNT_MAX     = 65536;
  localparam int unsigned HIT_W         = 32;
  localparam int unsigned CMD_W         = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_NORMAL = 3'd0,
    CMD_CRASH  = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_RESET  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_NEW_EDGE     = 3'd0,
    KIND_PASS_END     = 3'd1,
    KIND_CLEARED      = 3'd2,
    KIND_RESET_DONE   = 3'd3,
    KIND_COUNT_READ   = 3'd4,
    KIND_READ_REFUSED = 3'd5
  } kind_e;

  typedef enum logic [7:0] {
    ST_SWEEP = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_MAP   = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_PEND  = 8'b0001_0000,
    ST_CLEAR = 8'b0010_0000,
    ST_READ  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic [EDGE_W-1:0]   edge_idx;
    logic [COUNT_W-1:0]  pass_cnt;
    logic [COUNT_W-1:0]  total;
    logic [HIT_W-1:0]    hits;
    logic                last;
  } res_t;

  // bits of a map word that stand for edges below the capacity
  function automatic logic [WORD_BITS-1:0] valid_mask(logic [WIDX_W-1:0] w);
    logic [31:0] base;
    logic [31:0] rest;
    base = 32'(w) * 32'(WORD_BITS);
    rest = 32'(EDGE_CAPACITY) - base;
    if (32'(w) >= 32'(MAP_WORDS)) begin
      return '0;
    end else if (base + 32'(WORD_BITS) <= 32'(EDGE_CAPACITY)) begin
      return '1;
    end else begin
      return (WORD_BITS'(1) << rest) - WORD_BITS'(1);
    end
  endfunction

  // reset value of one map row, edge zero always clear
  function automatic logic [WORD_BITS-1:0] row_reset(logic [MAP_AW-1:0] r);
    logic [WORD_BITS-1:0] m;
    m = valid_mask(WIDX_W'(r));
    if (r == '0) begin
      m[0] = 1'b0;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/cbt_ram.sv
// cbt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/coverage_bitmap_new_edge_tracker_top.sv
// coverage_bitmap_new_edge_tracker_top: unseen-edge maps, hit counters and found total.
// Depends on cbt_pkg and cbt_ram.
// A trace word reads its map row, marks the fresh edges seen, then scans bit by bit up to its
// highest new or counted bit, waiting while a result finds the output register full; a pass
// end adds a pass-end step, and a final counter write-back on the single hit-counter port
// holds the next item. New items are taken only in idle, one at a time.
// Reset: rst_ni is asynchronous, active low; afterwards a clearing pass rewrites both maps
// and all hit counters while input is stalled. Reset all runs the same pass, then reports.
module coverage_bitmap_new_edge_tracker_top
  import cbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [WORD_BITS-1:0]  trace_word_i,
  input  logic [WIDX_W-1:0]     word_index_i,
  input  logic                  pass_end_i,
  input  logic [EDGE_W-1:0]     edge_index_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            kind_o,
  output logic [EDGE_W-1:0]     found_edge_o,
  output logic [COUNT_W-1:0]    pass_new_count_o,
  output logic [COUNT_W-1:0]    found_total_o,
  output logic [HIT_W-1:0]      hit_count_o,
  output logic                  last_result_o
);

  // control state
  state_e               state_q, state_d;
  logic                 track_q, track_d;
  logic [COUNT_W-1:0]   pass_q, pass_d;
  logic [COUNT_W-1:0]   found_q, found_d;
  logic [HIT_AW-1:0]    sweep_q, sweep_d;
  logic                 sweep_reply_q, sweep_reply_d;
  logic                 inc_pend_q, inc_pend_d;
  logic                 found_any_q, found_any_d;
  logic [BIT_W-1:0]     k_q, k_d;
  logic                 out_valid_q, out_valid_d;

  // item payload
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [WORD_BITS-1:0] bits_q, bits_d;
  logic [WORD_BITS-1:0] fresh_q, fresh_d;
  logic [WIDX_W-1:0]    widx_q, widx_d;
  logic                 pend_q, pend_d;
  logic [EDGE_W-1:0]    eidx_q, eidx_d;
  logic [HIT_AW-1:0]    inc_addr_q, inc_addr_d;
  res_t                 out_q, out_d;

  // memory ports
  logic                 nm_we, nm_re, cm_we, cm_re, ht_we, ht_re;
  logic [MAP_AW-1:0]    nm_waddr, nm_raddr, cm_waddr, cm_raddr;
  logic [WORD_BITS-1:0] nm_wdata, nm_rdata, cm_wdata, cm_rdata;
  logic [HIT_AW-1:0]    ht_waddr, ht_raddr;
  logic [HIT_W-1:0]     ht_wdata, ht_rdata;

  // helpers
  logic                 accept;
  logic                 out_free;
  logic [WORD_BITS-1:0] map_word;
  logic [WORD_BITS-1:0] fresh_new;
  logic                 scan_go;
  logic                 edge_ok;
  logic [HIT_AW-1:0]    scan_addr;

  cbt_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_normal_map (
    .clk_i   (clk_i),
    .we_i    (nm_we),
    .waddr_i (nm_waddr),
    .wdata_i (nm_wdata),
    .re_i    (nm_re),
    .raddr_i (nm_raddr),
    .rdata_o (nm_rdata)
  );

  cbt_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_crash_map (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (cm_wdata),
    .re_i    (cm_re),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  cbt_ram #(.WIDTH(HIT_W), .DEPTH(EDGE_CAPACITY)) u_hits (
    .clk_i   (clk_i),
    .we_i    (ht_we),
    .waddr_i (ht_waddr),
    .wdata_i (ht_wdata),
    .re_i    (ht_re),
    .raddr_i (ht_raddr),
    .rdata_o (ht_rdata)
  );

  // new items only in idle, and not while a counter increment is still being written
  assign in_stall_o = (state_q != ST_IDLE) || inc_pend_q;
  assign accept     = in_valid_i && !in_stall_o;
  // the output register can take a new beat this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  assign map_word  = (cmd_q == CMD_NORMAL) ? nm_rdata : cm_rdata;
  assign fresh_new = bits_q & map_word;
  // a bit that needs a result waits for room in the output register
  assign scan_go   = !fresh_q[0] || out_free;
  assign edge_ok   = 32'(eidx_q) < 32'(EDGE_CAPACITY);
  assign scan_addr = HIT_AW'({widx_q, k_q});

  always_comb begin
    state_d       = state_q;
    track_d       = track_q;
    pass_d        = pass_q;
    found_d       = found_q;
    sweep_d       = sweep_q;
    sweep_reply_d = sweep_reply_q;
    inc_pend_d    = 1'b0;
    found_any_d   = found_any_q;
    k_d           = k_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_d         = cmd_q;
    bits_d        = bits_q;
    fresh_d       = fresh_q;
    widx_d        = widx_q;
    pend_d        = pend_q;
    eidx_d        = eidx_q;
    inc_addr_d    = inc_addr_q;
    out_d         = out_q;

    nm_we    = 1'b0;
    nm_waddr = widx_q;
    nm_wdata = '0;
    cm_we    = 1'b0;
    cm_waddr = widx_q;
    cm_wdata = '0;
    ht_we    = 1'b0;
    ht_waddr = inc_addr_q;
    ht_wdata = '0;

    // reads issued on the accept edge: map row for trace and clear, counter for read
    nm_re    = accept && ((command_i == CMD_NORMAL) || (command_i == CMD_CLEAR));
    nm_raddr = (command_i == CMD_CLEAR) ? MAP_AW'(edge_index_i >> BIT_W) : word_index_i;
    cm_re    = accept && (command_i == CMD_CRASH);
    cm_raddr = word_index_i;
    ht_re    = accept && (command_i == CMD_READ);
    ht_raddr = HIT_AW'(edge_index_i);

    if (cfg_we_i) begin
      track_d = cfg_wdata_i;
    end

    // second half of a hit counter read-modify-write
    if (inc_pend_q) begin
      ht_we    = 1'b1;
      ht_waddr = inc_addr_q;
      ht_wdata = ht_rdata + HIT_W'(1);
    end

    unique case (state_q)
      ST_SWEEP: begin
        // clearing pass: one counter and, while in range, one row of each map a cycle
        ht_we    = 1'b1;
        ht_waddr = sweep_q;
        ht_wdata = '0;
        if (32'(sweep_q) < 32'(MAP_WORDS)) begin
          nm_we    = 1'b1;
          nm_waddr = MAP_AW'(sweep_q);
          nm_wdata = row_reset(MAP_AW'(sweep_q));
          cm_we    = 1'b1;
          cm_waddr = MAP_AW'(sweep_q);
          cm_wdata = row_reset(MAP_AW'(sweep_q));
        end
        if (sweep_q == HIT_AW'(EDGE_CAPACITY - 1)) begin
          state_d = sweep_reply_q ? ST_DONE : ST_IDLE;
        end else begin
          sweep_d = sweep_q + HIT_AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = command_i;
          widx_d = word_index_i;
          pend_d = pass_end_i;
          eidx_d = edge_index_i;
          bits_d = trace_word_i & valid_mask(word_index_i);
          unique case (command_i) inside
            CMD_NORMAL, CMD_CRASH: state_d = ST_MAP;
            CMD_CLEAR:             state_d = ST_CLEAR;
            CMD_READ:              state_d = ST_READ;
            CMD_RESET: begin
              state_d       = ST_SWEEP;
              sweep_d       = '0;
              sweep_reply_d = 1'b1;
              pass_d        = '0;
              found_d       = '0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MAP: begin
        // map row has arrived: mark the fresh edges seen
        fresh_d     = fresh_new;
        found_any_d = 1'b0;
        k_d         = '0;
        if (cmd_q == CMD_NORMAL) begin
          nm_we    = 1'b1;
          nm_waddr = widx_q;
          nm_wdata = map_word & ~fresh_new;
        end else begin
          cm_we    = 1'b1;
          cm_waddr = widx_q;
          cm_wdata = map_word & ~fresh_new;
        end
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // bit zero of the shift registers is the current edge
        if (scan_go) begin
          if (bits_q[0] && track_q) begin
            ht_re      = 1'b1;
            ht_raddr   = scan_addr;
            inc_pend_d = 1'b1;
            inc_addr_d = scan_addr;
          end
          if (fresh_q[0]) begin
            pass_d = (pass_q < COUNT_W'(COUNT_MAX)) ? pass_q + COUNT_W'(1) : pass_q;
            if (cmd_q == CMD_NORMAL) begin
              found_d = (found_q < COUNT_W'(COUNT_MAX)) ? found_q + COUNT_W'(1) : found_q;
            end
            out_d.kind     = KIND_NEW_EDGE;
            out_d.edge_idx = EDGE_W'({widx_q, k_q});
            out_d.pass_cnt = pass_d;
            out_d.total    = found_d;
            out_d.hits     = '0;
            out_d.last     = (fresh_q[WORD_BITS-1:1] == '0);
            out_valid_d    = 1'b1;
            found_any_d    = 1'b1;
          end
          bits_d  = bits_q >> 1;
          fresh_d = fresh_q >> 1;
          k_d     = k_q + BIT_W'(1);
          // stop once nothing above this bit needs a result or a count
          if ((fresh_q[WORD_BITS-1:1] == '0) &&
              (!track_q || (bits_q[WORD_BITS-1:1] == '0))) begin
            state_d = pend_q ? ST_PEND : ST_IDLE;
          end
        end
      end
      ST_PEND: begin
        if (found_any_q) begin
          pass_d  = '0;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d.kind     = KIND_PASS_END;
          out_d.edge_idx = '0;
          out_d.pass_cnt = pass_q;
          out_d.total    = found_q;
          out_d.hits     = '0;
          out_d.last     = 1'b1;
          out_valid_d    = 1'b1;
          pass_d         = '0;
          state_d        = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          if (edge_ok) begin
            if (track_q) begin
              ht_we    = 1'b1;
              ht_waddr = HIT_AW'(eidx_q);
              ht_wdata = '0;
            end
            found_d = (found_q != '0) ? found_q - COUNT_W'(1) : '0;
            if (eidx_q != '0) begin
              nm_we    = 1'b1;
              nm_waddr = MAP_AW'(eidx_q >> BIT_W);
              nm_wdata = nm_rdata | (WORD_BITS'(1) << eidx_q[BIT_W-1:0]);
            end
          end
          out_d.kind     = KIND_CLEARED;
          out_d.edge_idx = eidx_q;
          out_d.pass_cnt = pass_q;
          out_d.total    = found_d;
          out_d.hits     = '0;
          out_d.last     = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_d.kind     = track_q ? KIND_COUNT_READ : KIND_READ_REFUSED;
          out_d.edge_idx = eidx_q;
          out_d.pass_cnt = pass_q;
          out_d.total    = found_q;
          out_d.hits     = (track_q && edge_ok) ? ht_rdata : '0;
          out_d.last     = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.kind     = KIND_RESET_DONE;
          out_d.edge_idx = '0;
          out_d.pass_cnt = pass_q;
          out_d.total    = found_q;
          out_d.hits     = '0;
          out_d.last     = 1'b1;
          out_valid_d    = 1'b1;
          sweep_reply_d  = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      track_q       <= 1'b0;
      pass_q        <= '0;
      found_q       <= '0;
      sweep_q       <= '0;
      sweep_reply_q <= 1'b0;
      inc_pend_q    <= 1'b0;
      found_any_q   <= 1'b0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      track_q       <= track_d;
      pass_q        <= pass_d;
      found_q       <= found_d;
      sweep_q       <= sweep_d;
      sweep_reply_q <= sweep_reply_d;
      inc_pend_q    <= inc_pend_d;
      found_any_q   <= found_any_d;
      k_q           <= k_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    bits_q     <= bits_d;
    fresh_q    <= fresh_d;
    widx_q     <= widx_d;
    pend_q     <= pend_d;
    eidx_q     <= eidx_d;
    inc_addr_q <= inc_addr_d;
    out_q      <= out_d;
  end

  // output beat
  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign found_edge_o     = out_q.edge_idx;
  assign pass_new_count_o = out_q.pass_cnt;
  assign found_total_o    = out_q.total;
  assign hit_count_o      = out_q.hits;
  assign last_result_o    = out_q.last;

  // counter write-back only follows a scan step
  a_inc_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_pend_q |-> $past(state_q == ST_SCAN))
    else $error("hit counter write without a scan step");

  // a trace word always starts with its map row read
  a_trace_to_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((command_i == CMD_NORMAL) || (command_i == CMD_CRASH))) |=>
    (state_q == ST_MAP))
    else $error("trace beat did not enter map stage");

  // results come only from work states
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q != ST_IDLE) && (state_q != ST_SWEEP) &&
                                 (state_q != ST_MAP)))
    else $error("result beat from a non-emitting state");

  // found total saturates
  a_found_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= COUNT_W'(COUNT_MAX))
    else $error("found total above its ceiling");

endmodule

>>> test/coverage_bitmap_new_edge_tracker_top_tb.sv
// coverage_bitmap_new_edge_tracker_top_tb: self-checking bench for the new-edge tracker,
// with a cycle-free predictor of both unseen maps, the hit counters and the found totals.
// Depends on cbt_pkg and the coverage_bitmap_new_edge_tracker_top RTL.
module coverage_bitmap_new_edge_tracker_top_tb;
  import cbt_pkg::*;

  // a word that reports nothing can still keep the block scanning, so the settle wait covers a full scan
  localparam int SETTLE_CYCLES = 120;
  localparam int CHUNKS        = 6;
  localparam int CHUNK_BEATS   = 75;

  // one input beat as the bench keeps it
  typedef struct {
    cmd_e                cmd;
    logic [WORD_BITS-1:0] word;
    logic [WIDX_W-1:0]   widx;
    logic                pend;
    logic [EDGE_W-1:0]   eidx;
  } trace_beat_t;

  // dut ports; the bench-driven inputs are known from time zero
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic                 cfg_wdata_i  = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i    = '0;
  logic [WORD_BITS-1:0] trace_word_i = '0;
  logic [WIDX_W-1:0]    word_index_i = '0;
  logic                 pass_end_i   = 1'b0;
  logic [EDGE_W-1:0]    edge_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [2:0]           kind_o;
  logic [EDGE_W-1:0]    found_edge_o;
  logic [COUNT_W-1:0]   pass_new_count_o;
  logic [COUNT_W-1:0]   found_total_o;
  logic [HIT_W-1:0]     hit_count_o;
  logic                 last_result_o;

  // predictor state: one bit per edge still unseen, per-edge hit counts, both totals
  logic [WORD_BITS-1:0] unseen_norm  [0:MAP_WORDS-1];
  logic [WORD_BITS-1:0] unseen_crash [0:MAP_WORDS-1];
  logic [HIT_W-1:0]     hit_tally    [0:EDGE_CAPACITY-1];
  logic [COUNT_W-1:0]   total_found;
  logic [COUNT_W-1:0]   pass_found;
  logic                 hits_on = 1'b0;   // shadow of track_hits

  trace_beat_t trace_beats [$];   // beats waiting for the driver
  res_t        due_reports [$];   // reports the block still owes
  trace_beat_t cur_beat;
  res_t        want_rep;
  int unsigned beats_sent  = 0;
  int unsigned beats_taken = 0;
  int unsigned mismatches  = 0;
  int          resets_left = 2;   // random reset-all budget, each one costs a full sweep
  bit          calm        = 1'b0; // no idling on either side while set

  coverage_bitmap_new_edge_tracker_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .trace_word_i    (trace_word_i),
    .word_index_i    (word_index_i),
    .pass_end_i      (pass_end_i),
    .edge_index_i    (edge_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .found_edge_o    (found_edge_o),
    .pass_new_count_o(pass_new_count_o),
    .found_total_o   (found_total_o),
    .hit_count_o     (hit_count_o),
    .last_result_o   (last_result_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // every map row lies below the capacity, so only edge zero is masked off
  function automatic void wipe_tracker();
    foreach (unseen_norm[r]) begin
      unseen_norm[r]  = '1;
      unseen_crash[r] = '1;
    end
    unseen_norm[0][0]  = 1'b0;
    unseen_crash[0][0] = 1'b0;
    foreach (hit_tally[i]) hit_tally[i] = '0;
    total_found = '0;
    pass_found  = '0;
  endfunction

  // report stamped with the totals as they stand right now
  function automatic res_t make_report(kind_e kind, logic [EDGE_W-1:0] eno,
                                       logic [HIT_W-1:0] hits);
    res_t r;
    r.kind     = kind;
    r.edge_idx = eno;
    r.pass_cnt = pass_found;
    r.total    = total_found;
    r.hits     = hits;
    r.last     = 1'b0;
    return r;
  endfunction

  // apply one accepted beat and queue the reports it owes
  function automatic void predict_reports(trace_beat_t b);
    logic [WORD_BITS-1:0] row;
    logic [WORD_BITS-1:0] fresh;
    res_t                 batch [$];
    case (b.cmd) inside
      CMD_NORMAL, CMD_CRASH: begin
        if (b.word == '0 && !b.pend) return;
        row   = (b.cmd == CMD_NORMAL) ? unseen_norm[b.widx] : unseen_crash[b.widx];
        fresh = b.word & row;
        if (b.cmd == CMD_NORMAL) begin
          unseen_norm[b.widx] = row & ~fresh;
        end else begin
          unseen_crash[b.widx] = row & ~fresh;
        end
        for (int k = 0; k < WORD_BITS; k++) begin
          // counters see every set bit, edge zero and old edges too
          if (hits_on && b.word[k]) hit_tally[{b.widx, 6'(k)}] += 1;
          if (fresh[k]) begin
            if (pass_found < COUNT_MAX) pass_found += 1;
            if (b.cmd == CMD_NORMAL && total_found < COUNT_MAX) total_found += 1;
            batch.push_back(make_report(KIND_NEW_EDGE, {b.widx, 6'(k)}, '0));
          end
        end
        if (b.pend) begin
          if (batch.size() == 0) batch.push_back(make_report(KIND_PASS_END, '0, '0));
          pass_found = '0;
        end
      end
      CMD_CLEAR: begin
        if (hits_on) hit_tally[b.eidx] = '0;
        if (total_found != 0) total_found -= 1;
        if (b.eidx != 0) unseen_norm[b.eidx[15:6]][b.eidx[5:0]] = 1'b1;
        batch.push_back(make_report(KIND_CLEARED, b.eidx, '0));
      end
      CMD_RESET: begin
        wipe_tracker();
        batch.push_back(make_report(KIND_RESET_DONE, '0, '0));
      end
      CMD_READ: begin
        if (hits_on) begin
          batch.push_back(make_report(KIND_COUNT_READ, b.eidx, hit_tally[b.eidx]));
        end else begin
          batch.push_back(make_report(KIND_READ_REFUSED, b.eidx, '0));
        end
      end
      default: ;
    endcase
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_reports.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // trace word beat; the edge field is ignored by the block, so it gets noise
  function automatic void queue_word(cmd_e cmd, logic [WORD_BITS-1:0] word,
                                     logic [WIDX_W-1:0] row, logic pend);
    trace_beat_t b;
    b.cmd  = cmd;
    b.word = word;
    b.widx = row;
    b.pend = pend;
    b.eidx = EDGE_W'($urandom);
    trace_beats.push_back(b);
  endfunction

  // clear, read or reset-all beat; the trace fields get noise
  function automatic void queue_edge_op(cmd_e cmd, logic [EDGE_W-1:0] eno);
    trace_beat_t b;
    b.cmd  = cmd;
    b.word = {$urandom, $urandom};
    b.widx = WIDX_W'($urandom);
    b.pend = 1'($urandom);
    b.eidx = eno;
    trace_beats.push_back(b);
  endfunction

  // mostly a few hot rows so edges get hit again, counted and re-armed
  function automatic logic [WIDX_W-1:0] pick_row();
    if ($urandom_range(3, 0) == 0) return WIDX_W'($urandom);
    case ($urandom_range(5, 0))
      0:       return 10'd0;
      1:       return 10'd1;
      2:       return 10'd2;
      3:       return 10'd511;
      4:       return 10'd1022;
      default: return 10'd1023;
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(4, 0))
      0:       return {$urandom, $urandom};
      1:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2:       return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1, 0);
      3:       return '0;
      default: return {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [EDGE_W-1:0] pick_edge();
    if ($urandom_range(9, 0) < 7) return {pick_row(), 6'($urandom)};
    return EDGE_W'($urandom);
  endfunction

  // random passes: trace words with a pass end now and then, mixed with edge ops
  function automatic void queue_random(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (resets_left != 0 && $urandom_range(199, 0) == 0) begin
        resets_left--;
        queue_edge_op(CMD_RESET, EDGE_W'($urandom));
      end else if (roll < 45) begin
        queue_word(CMD_NORMAL, pick_word(), pick_row(), $urandom_range(3, 0) == 0);
      end else if (roll < 65) begin
        queue_word(CMD_CRASH, pick_word(), pick_row(), $urandom_range(3, 0) == 0);
      end else if (roll < 80) begin
        queue_edge_op(CMD_CLEAR, pick_edge());
      end else begin
        queue_edge_op(CMD_READ, pick_edge());
      end
    end
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: new beat goes out at the falling edge, acceptance seen at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    // a beat stays up, unchanged, until it is taken
    if (rst_ni && beats_sent == beats_taken) begin
      if (trace_beats.size() != 0 && (calm || $urandom_range(99, 0) >= 19)) begin
        cur_beat = trace_beats.pop_front();
        command_i    <= cur_beat.cmd;
        trace_word_i <= cur_beat.word;
        word_index_i <= cur_beat.widx;
        pass_end_i   <= cur_beat.pend;
        edge_index_i <= cur_beat.eidx;
        in_valid_i   <= 1'b1;
        beats_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // predictor runs on the accepted beat; during reset it mirrors the clearing of the stores
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      wipe_tracker();
    end else if (in_valid_i && !in_stall_o) begin
      predict_reports(cur_beat);
      beats_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall, each accepted report checked against the oldest one due
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99, 0) < 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report mismatch, expected none, actual kind %0d edge %0d",
                 $time, kind_o, found_edge_o);
      end else begin
        want_rep = due_reports.pop_front();
        check_field("kind", want_rep.kind, kind_o);
        check_field("found_edge", want_rep.edge_idx, found_edge_o);
        check_field("pass_new_count", want_rep.pass_cnt, pass_new_count_o);
        check_field("found_total", want_rep.total, found_total_o);
        check_field("hit_count", want_rep.hits, hit_count_o);
        check_field("last_result", want_rep.last, last_result_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // everything sent and reported, then room for a trailing silent word
  task automatic settle();
    while (trace_beats.size() != 0 || beats_sent != beats_taken || due_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_track_hits(input logic val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    hits_on = val;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, counting off
    write_track_hits(1'b0);
    queue_edge_op(CMD_READ, 16'd5);                       // refused while counting is off
    queue_word(CMD_NORMAL, '1, 10'd0, 1'b0);              // full row 0, edge zero never new
    queue_word(CMD_NORMAL, 64'h8000_0000_0000_0001, 10'd1023, 1'b1); // top row, both ends
    queue_word(CMD_NORMAL, 64'h8000_0000_0000_0001, 10'd1023, 1'b1); // nothing new, pass end
    queue_word(CMD_NORMAL, '0, 10'd5, 1'b0);              // silent word
    queue_word(CMD_CRASH, '1, 10'd0, 1'b1);               // crash map apart, total held
    queue_edge_op(CMD_CLEAR, 16'hffff);                   // highest edge re-armed
    queue_edge_op(CMD_CLEAR, 16'h0000);                   // edge zero stays clear
    settle();

    // directed, counting on
    write_track_hits(1'b1);
    queue_word(CMD_NORMAL, 64'h8000_0000_0000_0000, 10'd1023, 1'b0);
    queue_word(CMD_NORMAL, 64'h1, 10'd0, 1'b1);           // only edge zero, counted anyway
    queue_edge_op(CMD_READ, 16'h0000);
    queue_edge_op(CMD_READ, 16'hffff);
    queue_word(CMD_NORMAL, 64'h8000_0000_0000_0000, 10'd1023, 1'b0); // counted, no report
    queue_edge_op(CMD_READ, 16'hffff);
    queue_edge_op(CMD_CLEAR, 16'hffff);                   // zeroes the counter
    queue_edge_op(CMD_READ, 16'hffff);
    queue_word(CMD_CRASH, 64'haaaa_aaaa_aaaa_aaaa, 10'd512, 1'b0);
    queue_edge_op(CMD_RESET, 16'h1234);
    queue_edge_op(CMD_CLEAR, 16'h1234);                   // total already at its floor
    queue_edge_op(CMD_READ, 16'h8000);
    queue_word(CMD_NORMAL, 64'h5555_5555_5555_5555, 10'h155, 1'b1);
    settle();

    // random chunks; each boundary holds the sender until every report is back
    for (int c = 0; c < CHUNKS; c++) begin
      write_track_hits(c % 2 == 0);
      calm = (c == 2);
      queue_random(CHUNK_BEATS);
      settle();
    end

    if (mismatches == 0) begin
      $display("coverage_bitmap_new_edge_tracker_top_tb: PASS");
    end else begin
      $display("coverage_bitmap_new_edge_tracker_top_tb: FAIL");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run including the full-map clears
  initial begin
    #30_000_000;
    $display("coverage_bitmap_new_edge_tracker_top_tb: FAIL");
    $finish;
  end

endmodule

>>> coverage_bitmap_new_edge_tracker_top.f
hw/rtl/cbt_pkg.sv
hw/rtl/cbt_ram.sv
hw/rtl/coverage_bitmap_new_edge_tracker_top.sv
test/coverage_bitmap_new_edge_tracker_top_tb.sv
